// ----- sv/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer package
// Grid geometry, field widths, character codes, beat types and sequencer
// states shared by the console cell writer and its cell store.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int POS_W    = $clog2(CELLS);
  localparam int CURSOR_W = 11;
  localparam int INDEX_W  = 11;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd0;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUT,
    ST_MOVE,
    ST_BLANK,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } in_beat_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
  } out_beat_t;

  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [POS_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ----- sv/tccw_cell_store.sv -----
// ----------------------------------------------------------------------------
// Console cell store
// Single-port-write, single-port-read memory of character cells, with the
// attribute byte above the character byte and registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_store
  import tccw_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- sv/text_console_cell_writer.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer
// Keeps a grid of character cells and a cursor; puts characters, clears the
// screen and reads cells, with one result beat per command beat.
// ----------------------------------------------------------------------------
// A scroll moves each cell up one row by a read and then a write through the
// cell store, then blanks the last row with spaces in the current attribute.
// Busy stays high until the result cycle has ended, so a new command is taken
// only once the last one has given its result. After reset the store is wiped
// to zero with busy high; attribute writes still land.
// ----------------------------------------------------------------------------
module text_console_cell_writer
  import tccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  in_beat_t          request,
  output logic              busy,
  output logic              done,
  output out_beat_t         result,
  input  logic              attr_we,
  input  logic [ATTR_W-1:0] attr_wdata
);

  state_t            state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  idx, idx_next;
  logic [CELL_W-1:0] fill_val, fill_val_next;
  logic              wiping, wiping_next;
  logic [1:0]        tabs_left, tabs_left_next;
  logic              newline_move, newline_move_next;
  logic              rd_hit, rd_hit_next;
  logic [POS_W-1:0]  read_index, read_index_next;
  logic [CHAR_W-1:0] put_code, put_code_next;
  logic [ATTR_W-1:0] attr;
  logic [CELL_W-1:0] rdata;
  mem_req_t          mem_req;

  tccw_cell_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (attr_we) begin
      attr <= attr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_FILL;
      col          <= '0;
      row          <= '0;
      pos          <= '0;
      idx          <= '0;
      fill_val     <= '0;
      wiping       <= 1'b1;
      tabs_left    <= '0;
      newline_move <= 1'b0;
      rd_hit       <= 1'b0;
    end else begin
      state        <= state_next;
      col          <= col_next;
      row          <= row_next;
      pos          <= pos_next;
      idx          <= idx_next;
      fill_val     <= fill_val_next;
      wiping       <= wiping_next;
      tabs_left    <= tabs_left_next;
      newline_move <= newline_move_next;
      rd_hit       <= rd_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    read_index <= read_index_next;
    put_code   <= put_code_next;
  end

  always_comb begin
    state_next        = state;
    col_next          = col;
    row_next          = row;
    pos_next          = pos;
    idx_next          = idx;
    fill_val_next     = fill_val;
    wiping_next       = wiping;
    tabs_left_next    = tabs_left;
    newline_move_next = newline_move;
    rd_hit_next       = rd_hit;
    read_index_next   = read_index;
    put_code_next     = put_code;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          rd_hit_next       = 1'b0;
          tabs_left_next    = 2'd0;
          newline_move_next = 1'b0;
          unique case (request.operation)
            OP_PUT: begin
              unique case (request.char_code)
                CH_NEWLINE: begin
                  newline_move_next = 1'b1;
                  state_next        = ST_MOVE;
                end
                CH_BACKSPACE: begin
                  if (col == '0) begin
                    col_next = COL_W'(COLUMNS - 1);
                    if (row != '0) begin
                      row_next = row - 1'b1;
                      pos_next = pos - 1'b1;
                    end else begin
                      pos_next = POS_W'(COLUMNS - 1);
                    end
                  end else begin
                    col_next = col - 1'b1;
                    pos_next = pos - 1'b1;
                  end
                  tabs_left_next = 2'd1;
                  state_next     = ST_BLANK;
                end
                CH_TAB: begin
                  tabs_left_next = 2'd2;
                  state_next     = ST_MOVE;
                end
                default: begin
                  put_code_next = request.char_code;
                  state_next    = ST_PUT;
                end
              endcase
            end
            OP_CLEAR: begin
              col_next      = '0;
              row_next      = '0;
              pos_next      = '0;
              idx_next      = '0;
              fill_val_next = {attr, CH_SPACE};
              state_next    = ST_FILL;
            end
            OP_READ: begin
              rd_hit_next     = (32'(request.cell_index) < CELLS);
              read_index_next = POS_W'(request.cell_index);
              state_next      = ST_READ;
            end
            OP_NONE: begin
              state_next = ST_RESP;
            end
          endcase
        end
      end
      ST_PUT: begin
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        if (newline_move || col == COL_W'(COLUMNS - 1)) begin
          col_next = '0;
          if (row == ROW_W'(ROWS - 1)) begin
            pos_next      = POS_W'(CELLS - COLUMNS);
            idx_next      = '0;
            fill_val_next = {attr, CH_SPACE};
            state_next    = ST_SCR_RD;
          end else begin
            row_next   = row + 1'b1;
            pos_next   = newline_move ? pos - POS_W'(col) + POS_W'(COLUMNS) : pos + 1'b1;
            state_next = (tabs_left != 2'd0) ? ST_BLANK : ST_RESP;
          end
        end else begin
          col_next   = col + 1'b1;
          pos_next   = pos + 1'b1;
          state_next = (tabs_left != 2'd0) ? ST_BLANK : ST_RESP;
        end
      end
      ST_BLANK: begin
        tabs_left_next = tabs_left - 1'b1;
        state_next     = (tabs_left == 2'd2) ? ST_MOVE : ST_RESP;
      end
      ST_SCR_RD: begin
        state_next = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        if (idx == POS_W'(CELLS - COLUMNS - 1)) begin
          idx_next   = POS_W'(CELLS - COLUMNS);
          state_next = ST_FILL;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_SCR_RD;
        end
      end
      ST_FILL: begin
        if (idx == POS_W'(CELLS - 1)) begin
          wiping_next = 1'b0;
          if (wiping) begin
            state_next = ST_IDLE;
          end else begin
            state_next = (tabs_left != 2'd0) ? ST_BLANK : ST_RESP;
          end
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_READ: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_req = '0;
    unique case (state)
      ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        mem_req.wdata = {attr, put_code};
      end
      ST_BLANK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        mem_req.wdata = {attr, CH_BLANK};
      end
      ST_SCR_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = idx + POS_W'(COLUMNS);
      end
      ST_SCR_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx;
        mem_req.wdata = rdata;
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx;
        mem_req.wdata = fill_val;
      end
      ST_READ: begin
        mem_req.re    = rd_hit;
        mem_req.raddr = read_index;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_comb begin
    busy                   = (state != ST_IDLE);
    done                   = (state == ST_RESP);
    result.cursor_position = CURSOR_W'(pos);
    result.cell_char       = rd_hit ? rdata[CHAR_W-1:0] : '0;
    result.cell_attr       = rd_hit ? rdata[CELL_W-1:CHAR_W] : '0;
  end

`ifndef SYNTHESIS
  a_cursor_linear: assert property (@(posedge clk) disable iff (rst)
    32'(pos) == 32'(row) * COLUMNS + 32'(col))
    else $error("cursor position out of step with row and column");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> 32'(mem_req.waddr) < CELLS)
    else $error("cell store write beyond the grid");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.re |-> 32'(mem_req.raddr) < CELLS)
    else $error("cell store read beyond the grid");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start a command");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe not followed by idle");
`endif

endmodule
